### design/ordered_list_engine_assert.svh
// Assertion macros used by the ordered list engine checker
`ifndef ORDERED_LIST_ENGINE_ASSERT_SVH
`define ORDERED_LIST_ENGINE_ASSERT_SVH

// same-cycle implication, off while reset is asserted
`define OLE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off while reset is asserted
`define OLE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/olist_pkg.sv
// Shared types and constants of the ordered list engine
`timescale 1ns / 1ps
`default_nettype none

package olist_pkg;

	// defaults of the top-level parameters
	localparam int DEF_CAPACITY   = 64;
	localparam int DEF_ELEM_WIDTH = 32;
	localparam int MAX_ELEM_W     = 64;

	// fixed field widths
	localparam int ACT_W     = 2;
	localparam int POS_W     = 6;
	localparam int VAL_W     = 32;
	localparam int STAT_W    = 2;
	localparam int IDX_OUT_W = 6;
	localparam int CNT_OUT_W = 7;

	typedef enum logic [ACT_W-1:0] {
		ACT_APPEND = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_READ   = 2'd2,
		ACT_SEARCH = 2'd3
	} olist_act_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2,
		ST_MISS  = 2'd3
	} olist_status_t;

	typedef struct packed {
		olist_status_t        status;
		logic [VAL_W-1:0]     read_value;
		logic                 found;
		logic [IDX_OUT_W-1:0] found_index;
		logic [CNT_OUT_W-1:0] count;
		logic                 empty_res;
	} olist_res_t;

endpackage

`default_nettype wire

### design/olist_ram.sv
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
`default_nettype none

module olist_ram #(
	parameter int WIDTH = olist_pkg::DEF_ELEM_WIDTH,
	parameter int DEPTH = olist_pkg::DEF_CAPACITY,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

### design/olist_ctrl.sv
// Request sequencer: append, positional read, shift-down remove and linear search
`timescale 1ns / 1ps
`default_nettype none

module olist_ctrl #(
	parameter int CAPACITY   = olist_pkg::DEF_CAPACITY,
	parameter int ELEM_WIDTH = olist_pkg::DEF_ELEM_WIDTH,
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
	localparam int CW = $clog2(CAPACITY + 1)
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [olist_pkg::ACT_W-1:0]  action,
	input  wire logic [olist_pkg::POS_W-1:0]  position,
	input  wire logic [olist_pkg::VAL_W-1:0]  value,
	output logic                              res_valid,
	output olist_pkg::olist_res_t             res,
	input  wire logic                         res_take,
	output logic                              ram_we,
	output logic      [AW-1:0]                ram_waddr,
	output logic      [ELEM_WIDTH-1:0]        ram_wdata,
	output logic      [AW-1:0]                ram_raddr,
	input  wire logic [ELEM_WIDTH-1:0]        ram_rdata
);

	import olist_pkg::*;

	localparam int CMPW = (CW > POS_W) ? CW : POS_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_SHIFT,
		S_SEARCH,
		S_DONE
	} state_t;

	state_t                state_q;
	logic [CW-1:0]         cnt_q;
	logic [CW-1:0]         rd_idx_q;
	logic [ELEM_WIDTH-1:0] val_q;
	logic                  pend_s1;
	logic [CW-1:0]         idx_s1;
	olist_res_t            res_q;

	logic [MAX_ELEM_W-1:0] val_ext;
	logic [MAX_ELEM_W-1:0] rd_ext;
	logic [ELEM_WIDTH-1:0] val_elem;
	logic [CMPW-1:0]       pos_w;
	logic [CMPW-1:0]       cnt_w;
	logic                  pos_bad;
	logic                  full;
	logic                  more;
	logic                  hit;
	logic [CW-1:0]         idx_m1;
	logic [CW-1:0]         pos_c;

	function automatic olist_res_t pack_res(olist_status_t st, logic [VAL_W-1:0] rd,
			logic fnd, logic [CW-1:0] fidx, logic [CW-1:0] c);
		olist_res_t r;
		r.status      = st;
		r.read_value  = rd;
		r.found       = fnd;
		r.found_index = IDX_OUT_W'(fidx);
		r.count       = CNT_OUT_W'(c);
		r.empty_res   = (c == '0);
		return r;
	endfunction

	assign val_ext  = MAX_ELEM_W'(value);
	assign val_elem = val_ext[ELEM_WIDTH-1:0];
	assign rd_ext   = MAX_ELEM_W'(ram_rdata);
	assign pos_w    = CMPW'(position);
	assign cnt_w    = CMPW'(cnt_q);
	assign pos_bad  = (pos_w >= cnt_w);
	assign pos_c    = CW'(pos_w);
	assign full     = (cnt_q >= CW'(CAPACITY));
	assign more     = (rd_idx_q < cnt_q);
	assign hit      = pend_s1 && (ram_rdata == val_q);
	assign idx_m1   = idx_s1 - CW'(1);

	assign in_stall  = (state_q != S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cnt_q[AW-1:0];
		ram_wdata = val_elem;
		ram_raddr = rd_idx_q[AW-1:0];
		if (state_q == S_IDLE) begin
			ram_raddr = AW'(position);
			ram_we    = in_valid && (olist_act_t'(action) == ACT_APPEND) && !full;
		end else if (state_q == S_SHIFT) begin
			// entry idx moves down into idx-1
			ram_we    = pend_s1;
			ram_waddr = idx_m1[AW-1:0];
			ram_wdata = ram_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			rd_idx_q <= '0;
			val_q    <= '0;
			pend_s1  <= 1'b0;
			idx_s1   <= '0;
			res_q    <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						val_q   <= val_elem;
						pend_s1 <= 1'b0;
						unique case (olist_act_t'(action))
							ACT_APPEND: begin
								state_q <= S_DONE;
								if (full) begin
									res_q <= pack_res(ST_FULL, '0, 1'b0, '0, cnt_q);
								end else begin
									cnt_q <= cnt_q + CW'(1);
									res_q <= pack_res(ST_OK, '0, 1'b0, '0, cnt_q + CW'(1));
								end
							end
							ACT_REMOVE: begin
								if (pos_bad) begin
									res_q   <= pack_res(ST_RANGE, '0, 1'b0, '0, cnt_q);
									state_q <= S_DONE;
								end else begin
									rd_idx_q <= pos_c + CW'(1);
									state_q  <= S_SHIFT;
								end
							end
							ACT_READ: begin
								if (pos_bad) begin
									res_q   <= pack_res(ST_RANGE, '0, 1'b0, '0, cnt_q);
									state_q <= S_DONE;
								end else begin
									state_q <= S_READ;
								end
							end
							ACT_SEARCH: begin
								rd_idx_q <= '0;
								state_q  <= S_SEARCH;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_READ: begin
					res_q   <= pack_res(ST_OK, rd_ext[VAL_W-1:0], 1'b0, '0, cnt_q);
					state_q <= S_DONE;
				end
				S_SHIFT: begin
					if (more) begin
						pend_s1  <= 1'b1;
						idx_s1   <= rd_idx_q;
						rd_idx_q <= rd_idx_q + CW'(1);
					end else begin
						pend_s1 <= 1'b0;
						if (!pend_s1) begin
							cnt_q   <= cnt_q - CW'(1);
							res_q   <= pack_res(ST_OK, '0, 1'b0, '0, cnt_q - CW'(1));
							state_q <= S_DONE;
						end
					end
				end
				S_SEARCH: begin
					if (hit) begin
						res_q   <= pack_res(ST_OK, '0, 1'b1, idx_s1, cnt_q);
						pend_s1 <= 1'b0;
						state_q <= S_DONE;
					end else if (more) begin
						pend_s1  <= 1'b1;
						idx_s1   <= rd_idx_q;
						rd_idx_q <= rd_idx_q + CW'(1);
					end else if (!pend_s1) begin
						res_q   <= pack_res(ST_MISS, '0, 1'b0, '0, cnt_q);
						state_q <= S_DONE;
					end else begin
						pend_s1 <= 1'b0;
					end
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### design/ordered_list_engine.sv
// Result path: append and rejected requests go straight to the result; a read passes through
// the registered RAM read; remove walks the entries behind the position down by one;
// search walks from entry 0 until a match or the end of the list.
// Throughput: one request at a time; the next beat is taken the cycle after the
// result moves to the output register; the serial walk over the one RAM read port sets it.
// Reset: arst_n clears the count and the sequencer; list words stay undefined until appended.
`timescale 1ns / 1ps
`default_nettype none

module ordered_list_engine #(
	parameter int CAPACITY   = olist_pkg::DEF_CAPACITY,
	parameter int ELEM_WIDTH = olist_pkg::DEF_ELEM_WIDTH
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic [olist_pkg::ACT_W-1:0]      action,
	input  wire logic [olist_pkg::POS_W-1:0]      position,
	input  wire logic [olist_pkg::VAL_W-1:0]      value,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic      [olist_pkg::STAT_W-1:0]     status,
	output logic      [olist_pkg::VAL_W-1:0]      read_value,
	output logic                                  found,
	output logic      [olist_pkg::IDX_OUT_W-1:0]  found_index,
	output logic      [olist_pkg::CNT_OUT_W-1:0]  count,
	output logic                                  empty_res
);

	import olist_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	// sequencer <-> list RAM
	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [ELEM_WIDTH-1:0] ram_wdata;
	logic [AW-1:0]         ram_raddr;
	logic [ELEM_WIDTH-1:0] ram_rdata;

	// finished result from the sequencer
	logic       res_valid;
	olist_res_t res;
	logic       res_take;

	// output register
	logic       out_valid_q;
	olist_res_t out_q;

	// list words, one per entry, in insertion order
	olist_ram #(
		.WIDTH (ELEM_WIDTH),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// request sequencer: append without a RAM walk, RAM walk for remove and search
	olist_ctrl #(
		.CAPACITY   (CAPACITY),
		.ELEM_WIDTH (ELEM_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.action    (action),
		.position  (position),
		.value     (value),
		.res_valid (res_valid),
		.res       (res),
		.res_take  (res_take),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	// A result moves over when the register is empty or its beat leaves this cycle,
	// so the sequencer stays in its done state while a downstream stall holds the previous beat.
	assign res_take = res_valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload holds while stalled; no reset needed
	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_q.status;
	assign read_value  = out_q.read_value;
	assign found       = out_q.found;
	assign found_index = out_q.found_index;
	assign count       = out_q.count;
	assign empty_res   = out_q.empty_res;

endmodule

`default_nettype wire

### design/olist_checker.sv
// Port-level checks of the ordered list engine and their binding
`timescale 1ns / 1ps
`default_nettype none

`include "ordered_list_engine_assert.svh"

module olist_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             out_valid,
	input wire logic                             out_stall,
	input wire logic [olist_pkg::STAT_W-1:0]     status,
	input wire logic [olist_pkg::VAL_W-1:0]      read_value,
	input wire logic                             found,
	input wire logic [olist_pkg::IDX_OUT_W-1:0]  found_index,
	input wire logic [olist_pkg::CNT_OUT_W-1:0]  count,
	input wire logic                             empty_res
);

	import olist_pkg::*;

	`OLE_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(status) && $stable(read_value) && $stable(count), "result beat changed while stalled")
	`OLE_ASSERT_IMP(a_empty_flag, clk, arst_n, out_valid, empty_res == (count == '0), "empty flag disagrees with count")
	`OLE_ASSERT_IMP(a_fail_zero, clk, arst_n, out_valid && (status != ST_OK), (read_value == '0) && !found && (found_index == '0), "failed request carries data")
	`OLE_ASSERT_IMP(a_found_ok, clk, arst_n, out_valid && found, (status == ST_OK) && !empty_res, "hit reported without ok status")

endmodule

bind ordered_list_engine olist_checker u_olist_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.status      (status),
	.read_value  (read_value),
	.found       (found),
	.found_index (found_index),
	.count       (count),
	.empty_res   (empty_res)
);

`default_nettype wire

### tb/ordered_list_engine_tb.sv
// Self-checking testbench for the ordered list engine: directed table, then random traffic.
`timescale 1ns / 1ps

module ordered_list_engine_tb;
	import olist_pkg::*;

	localparam int DEPTH       = DEF_CAPACITY;
	localparam int N_DIRECTED  = 22;
	localparam int RAND_PER_PH = 234;
	// longest walk is a search or remove over a full list; leave margin for the drain at the end
	localparam int SETTLE      = DEPTH + 16;
	localparam int LIMIT       = 400000;

	typedef struct {
		olist_act_t act;
		logic [POS_W-1:0] pos;
		logic [VAL_W-1:0] val;
		bit typed;
		olist_res_t res;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [ACT_W-1:0] action;
	logic [POS_W-1:0] position;
	logic [VAL_W-1:0] value;
	logic out_valid;
	logic out_stall;
	logic [STAT_W-1:0] status;
	logic [VAL_W-1:0] read_value;
	logic found;
	logic [IDX_OUT_W-1:0] found_index;
	logic [CNT_OUT_W-1:0] count;
	logic empty_res;

	// shadow copy of the list
	logic [VAL_W-1:0] list_words [DEPTH];
	int list_len;
	olist_res_t pending_results [$];
	olist_res_t want;

	int tx_idle_pct;
	int rx_idle_pct;
	int mismatches;
	int checked;
	int cycles;
	int n_full, n_range, n_miss, n_hit, peak_len;

	ordered_list_engine dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.position(position),
		.value(value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.read_value(read_value),
		.found(found),
		.found_index(found_index),
		.count(count),
		.empty_res(empty_res)
	);

	always #10 clk = ~clk;

	// computes the result of one request and updates the shadow list
	function automatic olist_res_t apply_request(olist_act_t act, logic [POS_W-1:0] pos,
			logic [VAL_W-1:0] val);
		olist_res_t r;
		int i;
		r = '0;
		r.status = ST_OK;
		case (act)
			ACT_APPEND: begin
				if (list_len >= DEPTH) begin
					r.status = ST_FULL;
					n_full++;
				end else begin
					list_words[list_len] = val;
					list_len++;
				end
			end
			ACT_REMOVE: begin
				if (int'(pos) >= list_len) begin
					r.status = ST_RANGE;
					n_range++;
				end else begin
					// later entries close up by one
					for (i = int'(pos); i + 1 < list_len; i++)
						list_words[i] = list_words[i + 1];
					list_len--;
				end
			end
			ACT_READ: begin
				if (int'(pos) >= list_len) begin
					r.status = ST_RANGE;
					n_range++;
				end else begin
					r.read_value = list_words[pos];
				end
			end
			default: begin
				r.status = ST_MISS;
				for (i = 0; i < list_len; i++) begin
					if (list_words[i] == val) begin
						r.status = ST_OK;
						r.found = 1'b1;
						r.found_index = i[IDX_OUT_W-1:0];
						break;
					end
				end
				if (r.found)
					n_hit++;
				else
					n_miss++;
			end
		endcase
		r.count = list_len[CNT_OUT_W-1:0];
		r.empty_res = (list_len == 0);
		if (list_len > peak_len)
			peak_len = list_len;
		return r;
	endfunction

	function automatic dir_row_t make_row(olist_act_t a, int p, logic [VAL_W-1:0] v, bit typed,
			olist_status_t st, logic [VAL_W-1:0] rv, bit fnd, int fidx, int cnt);
		dir_row_t d;
		d.act = a;
		d.pos = p[POS_W-1:0];
		d.val = v;
		d.typed = typed;
		d.res.status = st;
		d.res.read_value = rv;
		d.res.found = fnd;
		d.res.found_index = fidx[IDX_OUT_W-1:0];
		d.res.count = cnt[CNT_OUT_W-1:0];
		d.res.empty_res = (cnt == 0);
		return d;
	endfunction

	// directed table; rows with typed = 0 take their expectation from the predictor
	function automatic dir_row_t directed_row(int k);
		case (k)
			0:  return make_row(ACT_READ,   0, 32'h0,        1, ST_RANGE, 32'h0,        0, 0, 0);
			1:  return make_row(ACT_REMOVE, 0, 32'h0,        1, ST_RANGE, 32'h0,        0, 0, 0);
			2:  return make_row(ACT_SEARCH, 0, 32'h0,        1, ST_MISS,  32'h0,        0, 0, 0);
			3:  return make_row(ACT_APPEND, 0, 32'h0,        1, ST_OK,    32'h0,        0, 0, 1);
			4:  return make_row(ACT_APPEND, 63, 32'hFFFFFFFF, 1, ST_OK,   32'h0,        0, 0, 2);
			5:  return make_row(ACT_APPEND, 0, 32'h0,        1, ST_OK,    32'h0,        0, 0, 3);
			6:  return make_row(ACT_APPEND, 0, 32'hA5A55A5A, 1, ST_OK,    32'h0,        0, 0, 4);
			7:  return make_row(ACT_READ,   0, 32'hFFFFFFFF, 1, ST_OK,    32'h0,        0, 0, 4);
			8:  return make_row(ACT_READ,   1, 32'h0,        1, ST_OK,    32'hFFFFFFFF, 0, 0, 4);
			9:  return make_row(ACT_READ,   63, 32'h0,       1, ST_RANGE, 32'h0,        0, 0, 4);
			10: return make_row(ACT_READ,   4, 32'h0,        1, ST_RANGE, 32'h0,        0, 0, 4);
			11: return make_row(ACT_SEARCH, 0, 32'h0,        1, ST_OK,    32'h0,        1, 0, 4);
			12: return make_row(ACT_SEARCH, 0, 32'hA5A55A5A, 0, ST_OK,    32'h0,        0, 0, 0);
			13: return make_row(ACT_SEARCH, 0, 32'h12345678, 0, ST_OK,    32'h0,        0, 0, 0);
			// tail removal, then look for the word that was dropped
			14: return make_row(ACT_REMOVE, 3, 32'h0,        0, ST_OK,    32'h0,        0, 0, 0);
			15: return make_row(ACT_SEARCH, 0, 32'hA5A55A5A, 0, ST_OK,    32'h0,        0, 0, 0);
			16: return make_row(ACT_REMOVE, 0, 32'h0,        0, ST_OK,    32'h0,        0, 0, 0);
			17: return make_row(ACT_READ,   0, 32'h0,        0, ST_OK,    32'h0,        0, 0, 0);
			18: return make_row(ACT_SEARCH, 0, 32'h0,        0, ST_OK,    32'h0,        0, 0, 0);
			19: return make_row(ACT_REMOVE, 63, 32'h0,       1, ST_RANGE, 32'h0,        0, 0, 2);
			20: return make_row(ACT_REMOVE, 1, 32'h0,        0, ST_OK,    32'h0,        0, 0, 0);
			default: return make_row(ACT_REMOVE, 0, 32'h0,   1, ST_OK,    32'h0,        0, 0, 0);
		endcase
	endfunction

	// one request beat; optional idle cycles first, held until taken
	task automatic send_beat(olist_act_t act, logic [POS_W-1:0] pos, logic [VAL_W-1:0] val,
			bit typed, olist_res_t typed_res);
		olist_res_t r;
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		position <= pos;
		value <= val;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		r = apply_request(act, pos, val);
		pending_results.push_back(typed ? typed_res : r);
	endtask

	// hold off until every pending result is back, then let the walk settle
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic [VAL_W-1:0] pick_word();
		int r;
		r = $urandom_range(99);
		if (r < 25)
			return VAL_W'($urandom_range(7));     // small pool, forces duplicates
		if (r < 35) begin
			case ($urandom_range(3))
				0: return 32'h00000000;
				1: return 32'hFFFFFFFF;
				2: return 32'h80000000;
				default: return 32'h7FFFFFFF;
			endcase
		end
		return $urandom;
	endfunction

	task automatic report_field(string name, logic [VAL_W-1:0] exp_v, logic [VAL_W-1:0] got_v);
		if (exp_v !== got_v) begin
			mismatches++;
			$display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
		end
	endtask

	// result side: random stall, compare every taken beat with the oldest expectation
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < rx_idle_pct);
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				$display("%0t ns: result beat with no request pending", $time);
			end else begin
				want = pending_results.pop_front();
				report_field("status", want.status, status);
				report_field("read_value", want.read_value, read_value);
				report_field("found", want.found, found);
				report_field("found_index", want.found_index, found_index);
				report_field("count", want.count, count);
				report_field("empty_res", want.empty_res, empty_res);
				checked++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		dir_row_t d;
		olist_act_t act;
		logic [POS_W-1:0] pos;
		logic [VAL_W-1:0] val;
		bit filling;
		int r;
		int ph;
		int n;

		arst_n <= 1'b0;
		in_valid <= 1'b0;
		action <= ACT_APPEND;
		position <= '0;
		value <= '0;
		out_stall <= 1'b0;
		tx_idle_pct = 37;
		rx_idle_pct = 76;
		list_len = 0;
		mismatches = 0;
		checked = 0;
		cycles = 0;
		n_full = 0;
		n_range = 0;
		n_miss = 0;
		n_hit = 0;
		peak_len = 0;
		filling = 1'b1;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (n = 0; n < N_DIRECTED; n++) begin
			d = directed_row(n);
			send_beat(d.act, d.pos, d.val, d.typed, d.res);
		end

		// three idle profiles; the request mix swings the list between empty and full
		for (ph = 0; ph < 3; ph++) begin
			drain_results();
			case (ph)
				0: begin
					tx_idle_pct = 37;
					rx_idle_pct = 76;
				end
				1: begin
					tx_idle_pct = 76;
					rx_idle_pct = 37;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			for (n = 0; n < RAND_PER_PH; n++) begin
				if (filling && list_len == DEPTH && $urandom_range(3) == 0)
					filling = 1'b0;
				else if (!filling && list_len == 0)
					filling = 1'b1;
				r = $urandom_range(99);
				if (r < (filling ? 70 : 15))
					act = ACT_APPEND;
				else if (r < (filling ? 78 : 65))
					act = ACT_REMOVE;
				else if (r < (filling ? 89 : 82))
					act = ACT_READ;
				else
					act = ACT_SEARCH;
				// mostly valid positions, a quarter anywhere in the field
				if (list_len > 0 && $urandom_range(3) != 0)
					pos = POS_W'($urandom_range(list_len - 1));
				else
					pos = POS_W'($urandom_range(63));
				if (act == ACT_SEARCH && list_len > 0 && $urandom_range(9) < 6)
					val = list_words[$urandom_range(list_len - 1)];
				else
					val = pick_word();
				send_beat(act, pos, val, 1'b0, '0);
			end
		end

		drain_results();

		$display("%0d results checked: %0d full-list appends, %0d out-of-range positions,",
			checked, n_full, n_range);
		$display("%0d search hits, %0d misses, list peaked at %0d entries",
			n_hit, n_miss, peak_len);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
